// File: hw/rtl/hmks_pkg.sv
// Shared types and constants for the 64-bit key store.
package hmks_pkg;

    localparam int ENTRIES     = 256;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 9;
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Request token that walks the cell row.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              hit;
        logic              claimed;
        logic [VAL_W-1:0]  rd;
    } req_t;

    // End-of-walk decision broadcast to every cell.
    typedef struct packed {
        logic commit;
        logic cancel;
    } resolve_t;

endpackage

// File: hw/rtl/hmks_cell.sv
// One storage cell of the key row: holds one entry and forwards the request token.
module hmks_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  hmks_pkg::req_t    req_in,
    input  hmks_pkg::resolve_t resolve,
    output hmks_pkg::req_t    req_out
);
    import hmks_pkg::*;

    logic             valid_reg, valid_next;
    logic             pend_reg, pend_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    req_t             req_reg, req_next;
    logic             match;

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        req_next   = req_in;
        match      = req_in.valid && valid_reg && (key_reg == req_in.key);

        // Settle a slot claimed during the last walk.
        if (resolve.commit && pend_reg) begin
            valid_next = 1'b1;
        end
        if (resolve.commit || resolve.cancel) begin
            pend_next = 1'b0;
        end

        if (match) begin
            req_next.hit = 1'b1;
            unique case (req_in.op)
                OP_PUT:    val_next    = req_in.value;
                OP_GET:    req_next.rd = val_reg;
                OP_REMOVE: valid_next  = 1'b0;
                default:   ;
            endcase
        end else if (req_in.valid && !valid_reg && !pend_reg && req_in.op == OP_PUT
                     && !req_in.claimed && !req_in.hit) begin
            // First free slot: take it tentatively until the walk ends.
            pend_next        = 1'b1;
            key_next         = req_in.key;
            val_next         = req_in.value;
            req_next.claimed = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            req_reg.valid <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            pend_reg      <= pend_next;
            req_reg.valid <= req_next.valid;
        end
        key_reg         <= key_next;
        val_reg         <= val_next;
        req_reg.op      <= req_next.op;
        req_reg.key     <= req_next.key;
        req_reg.value   <= req_next.value;
        req_reg.hit     <= req_next.hit;
        req_reg.claimed <= req_next.claimed;
        req_reg.rd      <= req_next.rd;
    end

    assign req_out = req_reg;

endmodule

// File: hw/rtl/hash_map_u64_key_store_top.sv
// Top level of the 64-bit key store: request intake, cell row and result output.
//
// Key-value store for 64-bit unsigned keys and signed 32-bit values with room
// for ENTRIES keys. Each input item is a put, get or remove; each produces
// exactly one result item carrying a status (done/found, key not present, pool
// full), the value read by a get (-1 otherwise) and the number of keys stored
// after the request. Entries live in a row of ENTRIES identical cells; a
// request token enters the first cell and moves one cell per clock, comparing
// its key against each cell and claiming the first free cell for an insert.
// When the token leaves the last cell the claim is committed or dropped by a
// single broadcast, and the result is registered from the outcome of the token
// walk through the cell row; one request is in flight at a time. The output
// register lets the next item be accepted while a result still waits; a second
// finished result is held internally and s_tready stays low until the first one
// is taken. No clearing pass is needed after reset: all cells start empty.
module hash_map_u64_key_store_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key [63:0], value [95:64]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value [31:0], entry_count [40:32], zero [47:41]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import hmks_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VAL_W-1:0]     rd;
        logic [OUT_CNT_W-1:0] cnt;
    } result_t;

    state_t           state_reg, state_next;
    req_t             inj_reg, inj_next;
    req_t             link [ENTRIES+1];
    req_t             tok;
    resolve_t         resolve;
    logic [CNT_W-1:0] count_reg, count_next;
    result_t          res;
    result_t          out_reg, out_next;
    result_t          hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Row of cells; the token register feeds the first cell.
    assign link[0] = inj_reg;
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        hmks_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req_in  (link[i]),
            .resolve (resolve),
            .req_out (link[i+1])
        );
    end
    assign tok = link[ENTRIES];

    // Decide the outcome once the token leaves the row.
    always_comb begin
        count_next     = count_reg;
        resolve.commit = 1'b0;
        resolve.cancel = 1'b0;
        res.status     = ST_OK;
        res.rd         = tok.rd;
        if (tok.valid) begin
            unique case (tok.op)
                OP_PUT: begin
                    if (!tok.hit) begin
                        if (tok.claimed) begin
                            resolve.commit = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                        end else begin
                            res.status = ST_FULL;
                        end
                    end
                end
                OP_GET: begin
                    if (!tok.hit) begin
                        res.status = ST_MISS;
                    end
                end
                OP_REMOVE: begin
                    if (!tok.hit) begin
                        res.status = ST_MISS;
                    end else if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: ;
            endcase
            resolve.cancel = !resolve.commit;
        end
        res.cnt = OUT_CNT_W'(count_next);
    end

    // Sequence intake, walk and output handoff.
    always_comb begin
        state_next   = state_reg;
        inj_next     = inj_reg;
        out_next     = out_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        inj_next.valid = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    inj_next.valid   = 1'b1;
                    inj_next.op      = s_tuser;
                    inj_next.key     = s_tdata[63:0];
                    inj_next.value   = s_tdata[95:64];
                    inj_next.hit     = 1'b0;
                    inj_next.claimed = 1'b0;
                    inj_next.rd      = '1;
                    state_next       = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok.valid) begin
                    if (m_valid_reg && !m_tready) begin
                        hold_next  = res;
                        state_next = ST_HOLD;
                    end else begin
                        out_next     = res;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_HOLD: begin
                if (m_tready) begin
                    out_next     = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            inj_reg.valid <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            inj_reg.valid <= inj_next.valid;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
        inj_reg.op      <= inj_next.op;
        inj_reg.key     <= inj_next.key;
        inj_reg.value   <= inj_next.value;
        inj_reg.hit     <= inj_next.hit;
        inj_reg.claimed <= inj_next.claimed;
        inj_reg.rd      <= inj_next.rd;
        out_reg         <= out_next;
        hold_reg        <= hold_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.cnt, out_reg.rd};

    // A token leaves the row only while a walk is in progress.
    a_exit_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok.valid |-> (state_reg == ST_WALK))
        else $error("token left the cell row outside a walk");

    // The key count never exceeds the pool size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("stored count above pool size");

    // A held result implies the output register is still occupied.
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_valid_reg)
        else $error("result held with output register empty");

    // An accepted item is injected into the row on the next cycle.
    a_inject: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (inj_reg.valid && state_reg == ST_WALK))
        else $error("accepted item not injected");

endmodule

// File: tb/hash_map_u64_key_store_top_test.sv
// Self-checking bench, 64-bit key store: directed + random put/get/remove traffic vs. a chained-table model.
module hash_map_u64_key_store_top_test;

    import hmks_pkg::*;

    // Operation code 3 has no meaning in the block; it must answer OK with no effect.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    localparam int          BUCKETS     = 128;
    localparam logic [63:0] HASH_MULT   = 64'd2654435761;
    localparam logic [8:0]  NULL_SLOT   = 9'(ENTRIES);
    localparam int          KEY_POOL_SZ = 288;       // a little more than the pool, to hit full
    localparam int          RANDOM_PER_PHASE = 195;
    localparam int          DRAIN_CYCLES = ENTRIES + 16;
    localparam int          CYCLE_LIMIT  = 3_000_000;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [VAL_W-1:0]     read_value;
        logic [OUT_CNT_W-1:0] entry_count;
    } store_result_t;

    // Expected-result store plus a chained hash table that mirrors the block.
    class key_store_scoreboard;
        store_result_t     awaited_results[$];
        logic [8:0]        bucket_head [BUCKETS];
        logic [KEY_W-1:0]  slot_key    [ENTRIES];
        logic [VAL_W-1:0]  slot_value  [ENTRIES];
        logic [8:0]        slot_link   [ENTRIES];
        bit                slot_used   [ENTRIES];
        int unsigned       keys_stored;
        int unsigned       mismatches, results_checked, peak_keys;
        int unsigned       new_puts, overwrites, full_rejects, get_hits, get_misses;
        int unsigned       remove_hits, remove_misses, nop_codes;

        function void clear_table();
            foreach (bucket_head[b]) bucket_head[b] = NULL_SLOT;
            foreach (slot_used[s]) begin
                slot_used[s]  = 1'b0;
                slot_key[s]   = '0;
                slot_value[s] = '0;
                slot_link[s]  = '0;
            end
            keys_stored = 0;
        endfunction

        function int bucket_of(logic [KEY_W-1:0] key);
            logic [63:0] product;
            product = key * HASH_MULT;
            return int'(product % BUCKETS);
        endfunction

        // Walk one chain; the walk is bounded at ENTRIES steps.
        function void walk_chain(input int bucket, input logic [KEY_W-1:0] key,
                                 output logic [8:0] found, output logic [8:0] pred);
            logic [8:0] cur, last;
            int         steps;
            cur   = bucket_head[bucket];
            last  = NULL_SLOT;
            found = NULL_SLOT;
            pred  = NULL_SLOT;
            steps = 0;
            while (cur < NULL_SLOT && steps < ENTRIES) begin
                if (slot_used[cur] && slot_key[cur] == key) begin
                    found = cur;
                    pred  = last;
                    return;
                end
                last = cur;
                cur  = slot_link[cur];
                steps++;
            end
        endfunction

        function store_result_t predict_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] value);
            store_result_t res;
            int            bucket;
            logic [8:0]    found, pred, free_slot;
            res.status     = ST_OK;
            res.read_value = '1;
            bucket         = bucket_of(key);
            walk_chain(bucket, key, found, pred);
            case (op)
                OP_PUT: begin
                    if (found != NULL_SLOT) begin
                        slot_value[found] = value;
                        overwrites++;
                    end else begin
                        free_slot = NULL_SLOT;
                        for (int s = ENTRIES - 1; s >= 0; s--)
                            if (!slot_used[s]) free_slot = 9'(s);
                        if (free_slot == NULL_SLOT) begin
                            res.status = ST_FULL;
                            full_rejects++;
                        end else begin
                            slot_used[free_slot]  = 1'b1;
                            slot_key[free_slot]   = key;
                            slot_value[free_slot] = value;
                            slot_link[free_slot]  = bucket_head[bucket];
                            bucket_head[bucket]   = free_slot;
                            keys_stored++;
                            new_puts++;
                        end
                    end
                end
                OP_GET: begin
                    if (found != NULL_SLOT) begin
                        res.read_value = slot_value[found];
                        get_hits++;
                    end else begin
                        res.status = ST_MISS;
                        get_misses++;
                    end
                end
                OP_REMOVE: begin
                    if (found == NULL_SLOT) begin
                        res.status = ST_MISS;
                        remove_misses++;
                    end else begin
                        if (pred == NULL_SLOT) bucket_head[bucket] = slot_link[found];
                        else slot_link[pred] = slot_link[found];
                        slot_used[found] = 1'b0;
                        if (keys_stored > 0) keys_stored--;
                        remove_hits++;
                    end
                end
                default: nop_codes++;
            endcase
            if (keys_stored > peak_keys) peak_keys = keys_stored;
            res.entry_count = keys_stored[OUT_CNT_W-1:0];
            return res;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            awaited_results.push_back(predict_request(op, key, value));
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 20) $display("mismatch: %s", what);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] read_value,
                          logic [OUT_CNT_W-1:0] entry_count);
            store_result_t want;
            if (awaited_results.size() == 0) begin
                report($sformatf("result with nothing pending: status %0d value %0d count %0d",
                                 status, $signed(read_value), entry_count));
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            if (status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 results_checked, status, want.status));
            if (read_value !== want.read_value)
                report($sformatf("result %0d read_value %0d, want %0d", results_checked,
                                 $signed(read_value), $signed(want.read_value)));
            if (entry_count !== want.entry_count)
                report($sformatf("result %0d entry_count %0d, want %0d",
                                 results_checked, entry_count, want.entry_count));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // key [63:0], value [95:64]
    logic [1:0]  s_tuser;    // operation [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;    // read_value [31:0], entry_count [40:32], zero [47:41]
    logic [1:0]  m_tuser;    // status [1:0]

    key_store_scoreboard sb;
    logic [KEY_W-1:0]    key_pool [KEY_POOL_SZ];
    int                  fill_ptr;
    int                  sender_idle_pct, receiver_stall_pct;
    int unsigned         cycle_count;

    // Per-phase operation mix in percent; whatever is left goes to the unused code.
    int put_pct    [4] = '{85, 85, 35, 20};
    int get_pct    [4] = '{ 8,  8, 40, 35};
    int remove_pct [4] = '{ 4,  4, 22, 42};
    // Per-phase idling: none, sender only, receiver only, both.
    int phase_idle  [4] = '{0, 55,  0, 23};
    int phase_stall [4] = '{0,  0, 55, 23};

    hash_map_u64_key_store_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result channel at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Check every result item the moment it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[40:32]);
    end

    // Watchdog: end a hung run.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Hold the item on the bus until the block takes it; idle first at the phase rate.
    task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, key, value);
    endtask

    // Pause the sender until every pending result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Mix fully random keys with keys that pile up in a handful of buckets.
    task automatic build_key_pool();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < KEY_POOL_SZ; i++) begin
            k = {$urandom, $urandom};
            case (i % 3)
                1:       k[6:0] = 7'(i % 5);
                2:       k = 64'(i) * 64'd128 + 64'd3;
                default: ;
            endcase
            key_pool[i] = k;
        end
    endtask

    task automatic random_item(int phase);
        int               roll;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        roll = $urandom_range(0, 99);
        if (roll < put_pct[phase])                                        op = OP_PUT;
        else if (roll < put_pct[phase] + get_pct[phase])                  op = OP_GET;
        else if (roll < put_pct[phase] + get_pct[phase] + remove_pct[phase]) op = OP_REMOVE;
        else                                                              op = OP_NOP;
        value = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            key = {$urandom, $urandom};    // almost surely absent
        end else if (op == OP_PUT && phase < 2) begin
            // Sweep the pool in order while filling, so the pool runs out.
            key      = key_pool[fill_ptr];
            fill_ptr = (fill_ptr + 1) % KEY_POOL_SZ;
        end else begin
            key = key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
        end
        send_item(op, key, value);
    endtask

    initial begin
        sb = new;
        sb.clear_table();
        build_key_pool();
        fill_ptr           = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_PUT;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: misses on an empty table, key and value extremes, overwrite,
        // the unused code, and removal from the middle and the head of one chain.
        send_item(OP_GET,    64'd0, 32'd0);
        send_item(OP_REMOVE, 64'd0, 32'd0);
        send_item(OP_PUT,    64'd0, 32'h7FFF_FFFF);
        send_item(OP_PUT,    '1,    32'h8000_0000);
        send_item(OP_GET,    64'd0, 32'd0);
        send_item(OP_GET,    '1,    32'd0);
        send_item(OP_PUT,    64'd0, 32'hFFFF_FFFF);
        send_item(OP_GET,    64'd0, 32'd0);
        send_item(OP_NOP,    '1,    32'h5A5A_A5A5);
        send_item(OP_PUT,    64'd5,   32'd1);
        send_item(OP_PUT,    64'd133, 32'd2);
        send_item(OP_PUT,    64'd261, 32'd3);
        send_item(OP_REMOVE, 64'd133, 32'd0);
        send_item(OP_GET,    64'd261, 32'd0);
        send_item(OP_GET,    64'd5,   32'd0);
        send_item(OP_GET,    64'd133, 32'd0);
        send_item(OP_REMOVE, 64'd261, 32'd0);
        send_item(OP_GET,    64'd5,   32'd0);
        send_item(OP_REMOVE, 64'd5,   32'd0);
        send_item(OP_REMOVE, 64'd5,   32'd0);
        send_item(OP_PUT,    64'h8000_0000_0000_0000, 32'd0);
        send_item(OP_REMOVE, '1,    32'd0);
        drain_results();

        // Random: fill past the pool size first, then churn with gets and removes.
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = phase_idle[phase];
            receiver_stall_pct = phase_stall[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) random_item(phase);
        end
        sender_idle_pct = 0;
        drain_results();
        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d new puts, %0d overwrites, %0d pool-full rejects, %0d unused codes",
                 sb.new_puts, sb.overwrites, sb.full_rejects, sb.nop_codes);
        $display("gets %0d hit / %0d miss, removes %0d hit / %0d miss, peak %0d keys, %0d checked",
                 sb.get_hits, sb.get_misses, sb.remove_hits, sb.remove_misses, sb.peak_keys,
                 sb.results_checked);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
